@@ sv/gsf_pkg.sv @@
package gsf_pkg;

    localparam int PIX_W       = 64;
    localparam int FETCH_BYTES = 9;
    localparam int FETCH_BITS  = FETCH_BYTES * 8;
    localparam int Q_DEPTH     = 2;

    localparam logic [1:0] MODE_LOAD_OFF = 2'd0;
    localparam logic [1:0] MODE_LOAD_BMP = 2'd1;
    localparam logic [1:0] MODE_RENDER   = 2'd2;

    localparam logic [1:0] CFG_FIRST_CHAR = 2'd0;
    localparam logic [1:0] CFG_LAST_CHAR  = 2'd1;
    localparam logic [1:0] CFG_LINE_BYTES = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;
    localparam logic [1:0] ST_CLAMPED = 2'd3;

    typedef enum logic [1:0] {
        K_WR_OFF = 2'd0,
        K_WR_BMP = 2'd1,
        K_REPORT = 2'd2,
        K_RENDER = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] load_index;
        logic [15:0] load_value;
        logic [15:0] char_code;
        logic [7:0]  row;
    } req_t;

    typedef struct packed {
        logic [63:0] pixels;
        logic [6:0]  width;
        logic [1:0]  status;
    } result_t;

    // one classified request between front and back
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  status;
        logic [15:0] index;
        logic [15:0] value;
        logic [19:0] prod;
    } cmd_t;

endpackage

@@ sv/gsf_ram.sv @@
module gsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/gsf_front.sv @@
module gsf_front #(
    parameter int OFFSET_ENTRIES = 256,
    parameter int BITMAP_BYTES   = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_addr,
    input  logic [15:0]   cfg_wdata,
    input  logic          start,
    input  gsf_pkg::req_t req,
    input  logic          full,
    output logic          push,
    output gsf_pkg::cmd_t cmd
);

    logic [15:0] first_char_reg;
    logic [15:0] last_char_reg;
    logic [11:0] line_bytes_reg;
    logic        keep;
    logic [15:0] idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_char_reg <= 16'd0;
            last_char_reg  <= 16'd127;
            line_bytes_reg <= 12'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                gsf_pkg::CFG_FIRST_CHAR: first_char_reg <= cfg_wdata;
                gsf_pkg::CFG_LAST_CHAR:  last_char_reg  <= cfg_wdata;
                gsf_pkg::CFG_LINE_BYTES: line_bytes_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    assign idx = req.char_code - first_char_reg;

    always_comb
    begin
        keep        = 1'b0;
        cmd.kind    = gsf_pkg::K_REPORT;
        cmd.status  = gsf_pkg::ST_OK;
        cmd.index   = {4'd0, req.load_index};
        cmd.value   = req.load_value;
        cmd.prod    = 20'(req.row) * 20'(line_bytes_reg);
        unique case (req.mode)
            gsf_pkg::MODE_LOAD_OFF:
            begin
                keep     = 32'(req.load_index) < 32'(OFFSET_ENTRIES);
                cmd.kind = gsf_pkg::K_WR_OFF;
            end
            gsf_pkg::MODE_LOAD_BMP:
            begin
                keep     = 32'(req.load_index) < 32'(BITMAP_BYTES);
                cmd.kind = gsf_pkg::K_WR_BMP;
            end
            gsf_pkg::MODE_RENDER:
            begin
                keep = 1'b1;
                if (req.char_code < first_char_reg || req.char_code >= last_char_reg)
                begin
                    cmd.status = gsf_pkg::ST_ABSENT;
                end
                else if (32'(idx) + 32'd1 >= 32'(OFFSET_ENTRIES))
                begin
                    cmd.status = gsf_pkg::ST_OUTSIDE;
                end
                else
                begin
                    cmd.kind  = gsf_pkg::K_RENDER;
                    cmd.index = idx;
                end
            end
            default: keep = 1'b0;
        endcase
    end

    // loads outside the store and unknown modes are dropped here
    assign push = start && !full && keep;

endmodule

@@ sv/gsf_queue.sv @@
module gsf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gsf_pkg::cmd_t din,
    input  logic          pop,
    output gsf_pkg::cmd_t dout,
    output logic          full,
    output logic          empty
);

    localparam int AW = $clog2(gsf_pkg::Q_DEPTH);

    gsf_pkg::cmd_t  slot_reg [gsf_pkg::Q_DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW:0]    count_reg;

    assign full  = count_reg == (AW+1)'(gsf_pkg::Q_DEPTH);
    assign empty = count_reg == '0;
    assign dout  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(gsf_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(gsf_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ sv/gsf_back.sv @@
module gsf_back #(
    parameter int OFFSET_ENTRIES = 256,
    parameter int BITMAP_BYTES   = 4096,
    parameter int MAX_WIDTH      = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  gsf_pkg::cmd_t    head,
    input  logic             empty,
    output logic             pop,
    output logic             done,
    output gsf_pkg::result_t result
);

    localparam int OFF_AW = $clog2(OFFSET_ENTRIES);
    localparam int BMP_AW = $clog2(BITMAP_BYTES);
    localparam int FB     = gsf_pkg::FETCH_BITS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_OFF0  = 6'b000010,
        S_OFF1  = 6'b000100,
        S_CHK   = 6'b001000,
        S_FETCH = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [OFF_AW-1:0] idx_reg, idx_next;
    logic [19:0]      prod_reg, prod_next;
    logic [15:0]      lo_reg, lo_next;
    logic [6:0]       w_reg, w_next;
    logic [1:0]       stat_reg, stat_next;
    logic [23:0]      start_reg, start_next;
    logic [BMP_AW-1:0] addr_reg, addr_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [3:0]       last_reg, last_next;
    logic [FB-1:0]    buf_reg, buf_next;
    logic             done_reg, done_next;
    gsf_pkg::result_t res_reg, res_next;

    logic              off_we, bmp_we;
    logic [OFF_AW-1:0] off_raddr;
    logic [15:0]       off_rdata;
    logic [BMP_AW-1:0] bmp_raddr;
    logic [7:0]        bmp_rdata;

    logic [16:0] diff;
    logic [24:0] end_bit;
    logic [21:0] last_byte;
    logic [20:0] first_byte;
    logic [FB-1:0] rev;
    logic [FB-1:0] shifted;
    logic [63:0]   mask;

    gsf_ram #(.WIDTH(16), .DEPTH(OFFSET_ENTRIES)) u_off_ram (
        .clk   (clk),
        .we    (off_we),
        .waddr (head.index[OFF_AW-1:0]),
        .wdata (head.value),
        .raddr (off_raddr),
        .rdata (off_rdata)
    );

    gsf_ram #(.WIDTH(8), .DEPTH(BITMAP_BYTES)) u_bmp_ram (
        .clk   (clk),
        .we    (bmp_we),
        .waddr (head.index[BMP_AW-1:0]),
        .wdata (head.value[7:0]),
        .raddr (bmp_raddr),
        .rdata (bmp_rdata)
    );

    assign pop       = (state_reg == S_IDLE) && !empty;
    assign off_we    = pop && (head.kind == gsf_pkg::K_WR_OFF);
    assign bmp_we    = pop && (head.kind == gsf_pkg::K_WR_BMP);
    assign off_raddr = (state_reg == S_IDLE) ? head.index[OFF_AW-1:0] : idx_reg + 1'b1;

    assign diff       = {1'b0, off_rdata} - {1'b0, lo_reg};
    assign end_bit    = {1'b0, start_reg} + 25'(w_reg) - 25'd1;
    assign last_byte  = end_bit[24:3];
    assign first_byte = start_reg[23:3];
    assign bmp_raddr  = (state_reg == S_CHK) ? first_byte[BMP_AW-1:0] : addr_reg;

    // stream bit p sits at buf_reg[FB-1-p]; pixel x is stream bit (start mod 8) + x
    always_comb
    begin
        for (int i = 0; i < FB; i++)
        begin
            rev[i] = buf_reg[FB-1-i];
        end
        shifted = rev >> start_reg[2:0];
        for (int i = 0; i < 64; i++)
        begin
            mask[i] = 7'(i) < w_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        prod_next  = prod_reg;
        lo_next    = lo_reg;
        w_next     = w_reg;
        stat_next  = stat_reg;
        start_next = start_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        buf_next   = buf_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    unique case (head.kind)
                        gsf_pkg::K_WR_OFF, gsf_pkg::K_WR_BMP: ;
                        gsf_pkg::K_REPORT:
                        begin
                            done_next = 1'b1;
                            res_next  = '{pixels: '0, width: '0, status: head.status};
                        end
                        gsf_pkg::K_RENDER:
                        begin
                            idx_next   = head.index[OFF_AW-1:0];
                            prod_next  = head.prod;
                            state_next = S_OFF0;
                        end
                        default: ;
                    endcase
                end
            end
            S_OFF0:
            begin
                state_next = S_OFF1;
            end
            S_OFF1:
            begin
                lo_next = lo_reg;
                if (diff[16] || diff == '0)
                begin
                    done_next  = 1'b1;
                    res_next   = '{pixels: '0, width: '0, status: gsf_pkg::ST_ABSENT};
                    state_next = S_IDLE;
                end
                else
                begin
                    if (diff[15:0] > 16'(MAX_WIDTH))
                    begin
                        w_next    = 7'(MAX_WIDTH);
                        stat_next = gsf_pkg::ST_CLAMPED;
                    end
                    else
                    begin
                        w_next    = diff[6:0];
                        stat_next = gsf_pkg::ST_OK;
                    end
                    start_next = {8'd0, lo_reg} + {1'b0, prod_reg, 3'b000};
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (32'(last_byte) >= 32'(BITMAP_BYTES))
                begin
                    done_next  = 1'b1;
                    res_next   = '{pixels: '0, width: '0, status: gsf_pkg::ST_OUTSIDE};
                    state_next = S_IDLE;
                end
                else
                begin
                    last_next  = 4'(last_byte - {1'b0, first_byte});
                    addr_next  = first_byte[BMP_AW-1:0] + 1'b1;
                    cnt_next   = '0;
                    buf_next   = '0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                for (int k = 0; k < gsf_pkg::FETCH_BYTES; k++)
                begin
                    if (cnt_reg == 4'(k))
                    begin
                        buf_next[FB-1-8*k -: 8] = bmp_rdata;
                    end
                end
                if (cnt_reg == last_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                done_next  = 1'b1;
                res_next   = '{pixels: shifted[63:0] & mask, width: w_reg, status: stat_reg};
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        // the first offset read returns while in S_OFF0
        if (state_reg == S_OFF0)
        begin
            lo_next = off_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        prod_reg  <= prod_next;
        lo_reg    <= lo_next;
        w_reg     <= w_next;
        stat_reg  <= stat_next;
        start_reg <= start_next;
        addr_reg  <= addr_next;
        cnt_reg   <= cnt_next;
        last_reg  <= last_next;
        buf_reg   <= buf_next;
        res_reg   <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ sv/glyph_scanline_fetch_top.sv @@
// Glyph row fetch for a proportional 1-bit font. A request is taken when start is
// high and busy is low; load requests write the offset table or the bitmap and give
// no result, render requests give one result on result, marked by a one-cycle done
// pulse that cannot be held off. A two-entry queue sits between the classifying
// front and the executing back, so busy rises only when both entries are taken.
// In the back a load or a render rejected by its character code is finished in
// S_IDLE; a render whose glyph turns out empty ends in S_OFF1 and one whose row
// lies outside the bitmap ends in S_CHK; a render that reaches the bitmap reads
// the 1 to 9 bitmap bytes the row spans in S_FETCH before S_EMIT. The two offsets
// and then the bytes come one per cycle from memories with a single read port.
module glyph_scanline_fetch_top #(
    parameter int OFFSET_ENTRIES = 256,
    parameter int BITMAP_BYTES   = 4096,
    parameter int MAX_WIDTH      = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [15:0]      cfg_wdata,
    input  logic             start,
    output logic             busy,
    input  gsf_pkg::req_t    req,
    output logic             done,
    output gsf_pkg::result_t result
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    gsf_pkg::cmd_t cmd_in;
    gsf_pkg::cmd_t cmd_head;

    gsf_front #(
        .OFFSET_ENTRIES (OFFSET_ENTRIES),
        .BITMAP_BYTES   (BITMAP_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .req       (req),
        .full      (full),
        .push      (push),
        .cmd       (cmd_in)
    );

    gsf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cmd_in),
        .pop   (pop),
        .dout  (cmd_head),
        .full  (full),
        .empty (empty)
    );

    gsf_back #(
        .OFFSET_ENTRIES (OFFSET_ENTRIES),
        .BITMAP_BYTES   (BITMAP_BYTES),
        .MAX_WIDTH      (MAX_WIDTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (cmd_head),
        .empty  (empty),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

    assign busy = full;

endmodule

@@ dv/tb_glyph_scanline_fetch_top.sv @@
module tb_glyph_scanline_fetch_top;

    localparam int OFFSET_ENTRIES = 256;
    localparam int BITMAP_BYTES   = 4096;
    localparam int MAX_WIDTH      = 64;
    localparam int FILL_BYTES     = 640;
    localparam int TAIL_BYTES     = 16;
    localparam int SETTLE_CYCLES  = 64;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int PHASE_ITEMS    = 200;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum bit {STEP_REG, STEP_REQ} step_kind_t;

    typedef struct {
        step_kind_t       kind;
        logic [1:0]       reg_idx;
        logic [15:0]      reg_val;
        gsf_pkg::req_t    rq;
        bit               typed;
        gsf_pkg::result_t want;
    } dir_step_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_addr = '0;
    logic [15:0]      cfg_wdata = '0;
    logic             start = 1'b0;
    logic             busy;
    gsf_pkg::req_t    req = '0;
    logic             done;
    gsf_pkg::result_t result;

    // shadow of the block's tables and registers
    logic [15:0] glyph_tbl [OFFSET_ENTRIES];
    logic [7:0]  font_mem [BITMAP_BYTES];
    bit          font_set [BITMAP_BYTES];
    logic [15:0] first_c = 16'd0;
    logic [15:0] last_c = 16'd127;
    logic [11:0] line_b = 12'd32;

    gsf_pkg::result_t pending_rows [$];
    gsf_pkg::result_t row_want;
    int unsigned      mismatch_cnt = 0;
    int unsigned      cycle_cnt = 0;

    glyph_scanline_fetch_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .result   (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb_glyph_scanline_fetch_top: FAIL");
            $finish;
        end
    end

    function automatic gsf_pkg::req_t mk_req(logic [1:0] m, logic [11:0] li,
                                             logic [15:0] lv, logic [15:0] ch,
                                             logic [7:0] rw);
        gsf_pkg::req_t r;
        r.mode       = m;
        r.load_index = li;
        r.load_value = lv;
        r.char_code  = ch;
        r.row        = rw;
        return r;
    endfunction

    function automatic gsf_pkg::result_t mk_res(logic [63:0] pix, logic [6:0] w,
                                                logic [1:0] st);
        gsf_pkg::result_t r;
        r.pixels = pix;
        r.width  = w;
        r.status = st;
        return r;
    endfunction

    // applies one request to the shadow state; returns 1 when it yields a result (every render)
    function automatic bit fetch_glyph_row(input gsf_pkg::req_t r,
                                           output gsf_pkg::result_t res);
        bit          has_res;
        int unsigned slot, wid, start_bit, last_byte, b, x;
        int          diff;
        logic [1:0]  st;
        has_res = 1'b0;
        res = '0;
        if (r.mode == gsf_pkg::MODE_LOAD_OFF)
        begin
            if (r.load_index < OFFSET_ENTRIES)
                glyph_tbl[r.load_index] = r.load_value;
        end
        else if (r.mode == gsf_pkg::MODE_LOAD_BMP)
        begin
            font_mem[r.load_index] = r.load_value[7:0];
            font_set[r.load_index] = 1'b1;
        end
        else if (r.mode == gsf_pkg::MODE_RENDER)
        begin
            has_res = 1'b1;
            if (r.char_code < first_c || r.char_code >= last_c)
                res.status = gsf_pkg::ST_ABSENT;
            else
            begin
                slot = r.char_code - first_c;
                if (slot + 1 >= OFFSET_ENTRIES)
                    res.status = gsf_pkg::ST_OUTSIDE;
                else
                begin
                    diff = int'(glyph_tbl[slot + 1]) - int'(glyph_tbl[slot]);
                    if (diff <= 0)
                        res.status = gsf_pkg::ST_ABSENT;
                    else
                    begin
                        wid = diff;
                        st = gsf_pkg::ST_OK;
                        if (wid > MAX_WIDTH)
                        begin
                            wid = MAX_WIDTH;
                            st = gsf_pkg::ST_CLAMPED;
                        end
                        start_bit = glyph_tbl[slot] + r.row * line_b * 8;
                        last_byte = (start_bit + wid - 1) >> 3;
                        if (last_byte >= BITMAP_BYTES)
                            res.status = gsf_pkg::ST_OUTSIDE;
                        else
                        begin
                            // msb of each byte is the leftmost column
                            for (x = 0; x < wid; x++)
                            begin
                                b = start_bit + x;
                                res.pixels[x] = font_mem[b >> 3][7 - (b & 7)];
                            end
                            res.width = 7'(wid);
                            res.status = st;
                        end
                    end
                end
            end
        end
        return has_res;
    endfunction

    // true when a render would touch a bitmap byte that was never loaded
    function automatic bit reads_unwritten(input gsf_pkg::req_t r);
        int unsigned slot, wid, start_bit, last_byte;
        int          diff;
        if (r.mode != gsf_pkg::MODE_RENDER)
            return 1'b0;
        if (r.char_code < first_c || r.char_code >= last_c)
            return 1'b0;
        slot = r.char_code - first_c;
        if (slot + 1 >= OFFSET_ENTRIES)
            return 1'b0;
        diff = int'(glyph_tbl[slot + 1]) - int'(glyph_tbl[slot]);
        if (diff <= 0)
            return 1'b0;
        wid = (diff > MAX_WIDTH) ? MAX_WIDTH : diff;
        start_bit = glyph_tbl[slot] + r.row * line_b * 8;
        last_byte = (start_bit + wid - 1) >> 3;
        if (last_byte >= BITMAP_BYTES)
            return 1'b0;
        for (int unsigned b = start_bit >> 3; b <= last_byte; b++)
        begin
            if (!font_set[b])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic gsf_pkg::req_t next_request();
        gsf_pkg::req_t r;
        int unsigned   pick, span, rmax, slot;
        r = mk_req(gsf_pkg::MODE_RENDER, 12'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            r.mode = gsf_pkg::MODE_LOAD_OFF;
            if ($urandom_range(0, 9) != 0)
            begin
                slot = $urandom_range(1, OFFSET_ENTRIES - 1);
                r.load_index = 12'(slot);
                if ($urandom_range(0, 7) != 0)
                    r.load_value = glyph_tbl[slot - 1] + 16'($urandom_range(0, 80));
            end
        end
        else if (pick < 30)
            r.mode = gsf_pkg::MODE_LOAD_BMP;
        else if (pick < 34)
            r.mode = MODE_UNUSED;
        else
        begin
            if (last_c > first_c && $urandom_range(0, 9) < 8)
            begin
                span = last_c - first_c;
                if (span > OFFSET_ENTRIES)
                    span = OFFSET_ENTRIES;
                r.char_code = first_c + 16'($urandom_range(0, span - 1));
            end
            else if ($urandom_range(0, 1) == 1)
                r.char_code = ($urandom_range(0, 1) == 1) ? last_c : first_c - 16'd1;
            // keep most rows near the stored scanlines
            if (line_b == 0)
                rmax = 255;
            else
                rmax = FILL_BYTES / line_b;
            if (rmax > 255)
                rmax = 255;
            if ($urandom_range(0, 4) != 0)
                r.row = 8'($urandom_range(0, rmax));
        end
        return r;
    endfunction

    task automatic issue(input gsf_pkg::req_t r, input bit typed,
                         input gsf_pkg::result_t want);
        gsf_pkg::result_t pred;
        req <= r;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (fetch_glyph_row(r, pred))
            pending_rows.push_back(typed ? want : pred);
    endtask

    task automatic pause(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        // a trailing load may still be in the back end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] a, input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(posedge clk);
        if (a == gsf_pkg::CFG_FIRST_CHAR)
            first_c = v;
        else if (a == gsf_pkg::CFG_LAST_CHAR)
            last_c = v;
        else if (a == gsf_pkg::CFG_LINE_BYTES)
            line_b = v[11:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [15:0] fc, input logic [15:0] lc,
                             input logic [15:0] lb, input bit gaps);
        int unsigned   burst_left;
        gsf_pkg::req_t r;
        drain();
        write_reg(gsf_pkg::CFG_FIRST_CHAR, fc);
        write_reg(gsf_pkg::CFG_LAST_CHAR, lc);
        write_reg(gsf_pkg::CFG_LINE_BYTES, lb);
        burst_left = $urandom_range(1, 24);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            do
                r = next_request();
            while (reads_unwritten(r));
            issue(r, 1'b0, '0);
            if (gaps)
            begin
                burst_left--;
                if (burst_left == 0)
                begin
                    pause($urandom_range(1, 12));
                    burst_left = $urandom_range(1, 24);
                end
            end
            if ($urandom_range(0, 299) == 0)
                drain();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_rows.size() == 0)
            begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10)
                    $display("unexpected result at cycle %0d: pixels %h width %0d status %0d",
                             cycle_cnt, result.pixels, result.width, result.status);
            end
            else
            begin
                row_want = pending_rows.pop_front();
                if (result.pixels !== row_want.pixels || result.width !== row_want.width ||
                    result.status !== row_want.status)
                begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("mismatch at cycle %0d: want %h/%0d/%0d got %h/%0d/%0d",
                                 cycle_cnt, row_want.pixels, row_want.width,
                                 row_want.status, result.pixels, result.width,
                                 result.status);
                end
            end
        end
    end

    initial
    begin
        dir_step_t   dir_tbl [$];
        int unsigned acc, pick;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the offset table, the low part of the bitmap and its last bytes;
        // renders that would touch any other byte before it is loaded are not sent
        acc = 0;
        for (int i = 0; i < OFFSET_ENTRIES; i++)
        begin
            issue(mk_req(gsf_pkg::MODE_LOAD_OFF, 12'(i), 16'(acc), 16'($urandom),
                         8'($urandom)), 1'b0, '0);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                acc += $urandom_range(1, 16);
            else if (pick == 8)
                acc += $urandom_range(65, 90);
            else if (pick == 9 && acc > 8)
                acc -= $urandom_range(1, 8);
        end
        for (int i = 0; i < FILL_BYTES; i++)
            issue(mk_req(gsf_pkg::MODE_LOAD_BMP, 12'(i), 16'($urandom), 16'($urandom),
                         8'($urandom)), 1'b0, '0);
        for (int i = BITMAP_BYTES - TAIL_BYTES; i < BITMAP_BYTES; i++)
            issue(mk_req(gsf_pkg::MODE_LOAD_BMP, 12'(i), 16'($urandom), 16'($urandom),
                         8'($urandom)), 1'b0, '0);

        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_RENDER, 12'd0, 16'd0, 16'd127, 8'd0), 1'b1,
            mk_res(64'd0, 7'd0, gsf_pkg::ST_ABSENT)});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_RENDER, 12'hFFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b1,
            mk_res(64'd0, 7'd0, gsf_pkg::ST_ABSENT)});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(MODE_UNUSED, 12'hFFF, 16'hFFFF, 16'd0, 8'hFF), 1'b0, '0});
        // offset load beyond the table is dropped
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_LOAD_OFF, 12'hFFF, 16'hFFFF, 16'd0, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_LOAD_OFF, 12'd0, 16'd0, 16'd0, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_LOAD_OFF, 12'd1, 16'd8, 16'd0, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_LOAD_BMP, 12'd0, 16'hFFA5, 16'd0, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_RENDER, 12'd0, 16'd0, 16'd0, 8'd0), 1'b1,
            mk_res(64'hA5, 7'd8, gsf_pkg::ST_OK)});
        // zero width, then negative width
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_LOAD_OFF, 12'd2, 16'd8, 16'd0, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_RENDER, 12'd0, 16'd0, 16'd1, 8'd0), 1'b1,
            mk_res(64'd0, 7'd0, gsf_pkg::ST_ABSENT)});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_LOAD_OFF, 12'd3, 16'd4, 16'd0, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_RENDER, 12'd0, 16'd0, 16'd2, 8'd0), 1'b1,
            mk_res(64'd0, 7'd0, gsf_pkg::ST_ABSENT)});
        // wide glyph gets clamped
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_LOAD_OFF, 12'd4, 16'd104, 16'd0, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_RENDER, 12'd0, 16'd0, 16'd3, 8'd1), 1'b0, '0});
        // last byte of the bitmap, then one bit past it
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_LOAD_OFF, 12'd5, 16'd32760, 16'd0, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_LOAD_OFF, 12'd6, 16'd32768, 16'd0, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_RENDER, 12'd0, 16'd0, 16'd5, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_LOAD_OFF, 12'd7, 16'd32769, 16'd0, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_RENDER, 12'd0, 16'd0, 16'd6, 8'd0), 1'b1,
            mk_res(64'd0, 7'd0, gsf_pkg::ST_OUTSIDE)});
        // clamped fetch that still fits, then one that runs off the end
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_LOAD_OFF, 12'd8, 16'd32700, 16'd0, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_LOAD_OFF, 12'd9, 16'd32900, 16'd0, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_RENDER, 12'd0, 16'd0, 16'd8, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_LOAD_OFF, 12'd10, 16'd33000, 16'd0, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_RENDER, 12'd0, 16'd0, 16'd9, 8'd0), 1'b1,
            mk_res(64'd0, 7'd0, gsf_pkg::ST_OUTSIDE)});
        // last table entry has no right neighbor
        dir_tbl.push_back('{STEP_REG, gsf_pkg::CFG_LAST_CHAR, 16'hFFFF, '0, 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_RENDER, 12'd0, 16'd0, 16'd255, 8'd0), 1'b1,
            mk_res(64'd0, 7'd0, gsf_pkg::ST_OUTSIDE)});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_RENDER, 12'd0, 16'd0, 16'd254, 8'd0), 1'b0, '0});
        dir_tbl.push_back('{STEP_REG, gsf_pkg::CFG_LINE_BYTES, 16'd4095, '0, 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_RENDER, 12'd0, 16'd0, 16'd0, 8'd255), 1'b1,
            mk_res(64'd0, 7'd0, gsf_pkg::ST_OUTSIDE)});
        // zero scanline length folds every row onto row zero
        dir_tbl.push_back('{STEP_REG, gsf_pkg::CFG_LINE_BYTES, 16'd0, '0, 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_RENDER, 12'd0, 16'd0, 16'd0, 8'd200), 1'b1,
            mk_res(64'hA5, 7'd8, gsf_pkg::ST_OK)});
        // empty character range
        dir_tbl.push_back('{STEP_REG, gsf_pkg::CFG_FIRST_CHAR, 16'hFFFF, '0, 1'b0, '0});
        dir_tbl.push_back('{STEP_REQ, gsf_pkg::CFG_FIRST_CHAR, 16'd0,
            mk_req(gsf_pkg::MODE_RENDER, 12'd0, 16'd0, 16'hFFFF, 8'd0), 1'b1,
            mk_res(64'd0, 7'd0, gsf_pkg::ST_ABSENT)});

        foreach (dir_tbl[i])
        begin
            if (dir_tbl[i].kind == STEP_REG)
            begin
                drain();
                write_reg(dir_tbl[i].reg_idx, dir_tbl[i].reg_val);
            end
            else if (dir_tbl[i].typed || !reads_unwritten(dir_tbl[i].rq))
                issue(dir_tbl[i].rq, dir_tbl[i].typed, dir_tbl[i].want);
        end

        run_phase(16'd0, 16'd127, 16'd32, 1'b1);
        run_phase(16'd0, 16'hFFFF, 16'd1, 1'b0);
        run_phase(16'd40, 16'd200, 16'd4095, 1'b1);
        run_phase(16'd3, 16'd300, 16'd0, 1'b1);
        acc = $urandom_range(0, 300);
        run_phase(16'(acc), 16'(acc + $urandom_range(0, 400)), 16'($urandom_range(1, 80)),
                  1'b1);
        drain();

        if (mismatch_cnt == 0 && pending_rows.size() == 0)
            $display("tb_glyph_scanline_fetch_top: PASS");
        else
            $display("tb_glyph_scanline_fetch_top: FAIL");
        $finish;
    end

endmodule
